// ----- hw/rtl/i2c_master_byte_engine_defines.svh -----
// assertion macros for the i2c master byte engine
`ifndef I2C_MASTER_BYTE_ENGINE_DEFINES_SVH
`define I2C_MASTER_BYTE_ENGINE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define IMBE_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define IMBE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/imbe_pkg.sv -----
// package for the i2c master byte engine: codes, widths and bcd helper
package imbe_pkg;

   // widths of the payload fields and state
   localparam int FUNC_W  = 3;
   localparam int BYTE_W  = 8;
   localparam int DELAY_W = 16;
   localparam int BIT_W   = 4;
   localparam int CSR_AW  = 3;
   localparam int CSR_DW  = 32;

   // command and operation codes
   localparam logic [FUNC_W-1:0] OP_IDLE  = 3'd0;
   localparam logic [FUNC_W-1:0] OP_START = 3'd1;
   localparam logic [FUNC_W-1:0] OP_STOP  = 3'd2;
   localparam logic [FUNC_W-1:0] OP_WRITE = 3'd3;
   localparam logic [FUNC_W-1:0] OP_READ  = 3'd4;

   // phase codes within a clocked bit
   localparam logic PH_HIGH = 1'b0;
   localparam logic PH_LOW  = 1'b1;

   // register index of delay_ticks
   localparam logic REG_DELAY = 1'b0;

   localparam logic [DELAY_W-1:0] DELAY_RESET = 16'd5;
   localparam logic [BIT_W-1:0]   BITS_PER_BYTE = 4'd8;

   // two bcd digits to binary, high*10+low
   function automatic logic [BYTE_W-1:0] bcd_to_bin(input logic [BYTE_W-1:0] val);
      logic [BYTE_W-1:0] hi;
      logic [BYTE_W-1:0] lo;
      hi = {4'd0, val[7:4]};
      lo = {4'd0, val[3:0]};
      return (hi << 3) + (hi << 1) + lo;
   endfunction

endpackage

// ----- hw/rtl/i2c_master_byte_engine.sv -----
// i2c master byte engine: ticked start, stop, write and read pin sequencer
// result: the result for a tick is registered and shown in the cycle after acceptance
// throughput: one tick transaction per clock cycle, set by a single registered
//    pass through the pin sequencer; a result held by rsp_stall stalls the input
// reset: synchronous, active high; idle, scl and sda released, delay_ticks = 5
`include "i2c_master_byte_engine_defines.svh"

module i2c_master_byte_engine (
   input  logic                          clock,
   input  logic                          reset,
   // tick and command channel
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [imbe_pkg::FUNC_W-1:0]   req_func,
   input  logic [imbe_pkg::BYTE_W-1:0]   req_tx_byte,
   input  logic                          req_ack_send,
   input  logic                          req_sda_in,
   // result channel
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_scl_level,
   output logic                          rsp_sda_level,
   output logic                          rsp_busy_res,
   output logic                          rsp_done_res,
   output logic [imbe_pkg::BYTE_W-1:0]   rsp_rx_byte,
   output logic [imbe_pkg::BYTE_W-1:0]   rsp_rx_binary,
   // register port
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [imbe_pkg::CSR_AW-1:0]   csr_paddr,
   input  logic [imbe_pkg::CSR_DW-1:0]   csr_pwdata,
   output logic [imbe_pkg::CSR_DW-1:0]   csr_prdata,
   output logic                          csr_pready
);
   import imbe_pkg::*;

   // delay register
   logic [DELAY_W-1:0] delay_ff, delay_in;
   logic [DELAY_W-1:0] eff_delay;

   // sequencer state
   logic [FUNC_W-1:0]  op_ff, op_in;
   logic               phase_ff, phase_in;
   logic [BIT_W-1:0]   bit_idx_ff, bit_idx_in;
   logic [DELAY_W-1:0] dly_cnt_ff, dly_cnt_in;
   logic [BYTE_W-1:0]  shift_ff, shift_in;
   logic               ack_hold_ff, ack_hold_in;
   logic               scl_ff, scl_in;
   logic               sda_ff, sda_in;
   logic [BYTE_W-1:0]  rx_ff, rx_in;
   logic               done_in;

   // output register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               o_scl_ff, o_sda_ff, o_busy_ff, o_done_ff;
   logic [BYTE_W-1:0]  o_rx_ff, o_bin_ff;

   logic               accept;
   logic               csr_wr;
   logic [BYTE_W-1:0]  shift_nx;
   logic [BIT_W-1:0]   bit_nx;

   // handshake
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;
   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   // register port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_prdata = (csr_paddr[CSR_AW-1] == REG_DELAY)
                       ? {{(CSR_DW-DELAY_W){1'b0}}, delay_ff} : '0;
   assign delay_in   = (csr_wr && csr_paddr[CSR_AW-1] == REG_DELAY)
                       ? csr_pwdata[DELAY_W-1:0] : delay_ff;

   // a zero delay acts as one tick
   assign eff_delay = (delay_ff == '0) ? {{(DELAY_W-1){1'b0}}, 1'b1} : delay_ff;

   assign bit_nx = bit_idx_ff + 1'b1;

   // next state for one tick
   always_comb begin
      op_in       = op_ff;
      phase_in    = phase_ff;
      bit_idx_in  = bit_idx_ff;
      dly_cnt_in  = dly_cnt_ff;
      shift_in    = shift_ff;
      ack_hold_in = ack_hold_ff;
      scl_in      = scl_ff;
      sda_in      = sda_ff;
      rx_in       = rx_ff;
      done_in     = 1'b0;
      shift_nx    = shift_ff;

      if (op_ff == OP_IDLE) begin
         // command launch
         unique case (req_func)
            OP_START: begin
               op_in = OP_START; sda_in = 1'b1; scl_in = 1'b1;
            end
            OP_STOP: begin
               op_in = OP_STOP; sda_in = 1'b0; scl_in = 1'b1;
            end
            OP_WRITE: begin
               op_in = OP_WRITE; shift_in = req_tx_byte;
               sda_in = req_tx_byte[BYTE_W-1]; scl_in = 1'b1;
            end
            OP_READ: begin
               op_in = OP_READ; shift_in = '0; ack_hold_in = req_ack_send;
               sda_in = 1'b1; scl_in = 1'b1;
            end
            default: begin
            end
         endcase
         if (op_in != OP_IDLE) begin
            bit_idx_in = '0;
            phase_in   = PH_HIGH;
            dly_cnt_in = eff_delay;
         end
      end else if (dly_cnt_ff <= {{(DELAY_W-1){1'b0}}, 1'b1}) begin
         // delay ran out: next pin step
         unique case (op_ff)
            OP_START: begin
               if (phase_ff == PH_HIGH) begin
                  sda_in = 1'b0; phase_in = PH_LOW; dly_cnt_in = eff_delay;
               end else begin
                  scl_in = 1'b0; done_in = 1'b1;
               end
            end
            OP_STOP: begin
               sda_in = 1'b1; done_in = 1'b1;
            end
            OP_WRITE: begin
               if (phase_ff == PH_LOW) begin
                  scl_in = 1'b1; phase_in = PH_HIGH; dly_cnt_in = eff_delay;
               end else begin
                  scl_in = 1'b0;
                  if (bit_idx_ff >= BITS_PER_BYTE) begin
                     done_in = 1'b1;
                  end else begin
                     shift_nx   = {shift_ff[BYTE_W-2:0], 1'b0};
                     shift_in   = shift_nx;
                     bit_idx_in = bit_nx;
                     sda_in     = (bit_nx < BITS_PER_BYTE) ? shift_nx[BYTE_W-1] : 1'b1;
                     phase_in   = PH_LOW;
                     dly_cnt_in = eff_delay;
                  end
               end
            end
            OP_READ: begin
               if (phase_ff == PH_LOW) begin
                  scl_in = 1'b1; phase_in = PH_HIGH; dly_cnt_in = eff_delay;
               end else begin
                  scl_in = 1'b0;
                  if (bit_idx_ff >= BITS_PER_BYTE) begin
                     done_in = 1'b1;
                  end else begin
                     shift_nx   = {shift_ff[BYTE_W-2:0], req_sda_in};
                     shift_in   = shift_nx;
                     bit_idx_in = bit_nx;
                     if (bit_nx == BITS_PER_BYTE) begin
                        rx_in  = shift_nx;
                        sda_in = ~ack_hold_ff;
                     end
                     phase_in   = PH_LOW;
                     dly_cnt_in = eff_delay;
                  end
               end
            end
            default: begin
               // unused operation code falls back to idle
            end
         endcase
         // finish: completion or an unknown operation returns to idle
         if (done_in || !(op_ff == OP_START || op_ff == OP_STOP ||
                          op_ff == OP_WRITE || op_ff == OP_READ)) begin
            op_in      = OP_IDLE;
            phase_in   = PH_HIGH;
            bit_idx_in = '0;
            dly_cnt_in = '0;
         end
      end else begin
         dly_cnt_in = dly_cnt_ff - 1'b1;
      end
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= DELAY_RESET;
         op_ff        <= OP_IDLE;
         phase_ff     <= PH_HIGH;
         bit_idx_ff   <= '0;
         dly_cnt_ff   <= '0;
         shift_ff     <= '0;
         ack_hold_ff  <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
         rx_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         delay_ff     <= delay_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            op_ff       <= op_in;
            phase_ff    <= phase_in;
            bit_idx_ff  <= bit_idx_in;
            dly_cnt_ff  <= dly_cnt_in;
            shift_ff    <= shift_in;
            ack_hold_ff <= ack_hold_in;
            scl_ff      <= scl_in;
            sda_ff      <= sda_in;
            rx_ff       <= rx_in;
         end
      end
   end

   // result payload register
   always_ff @(posedge clock) begin
      if (accept) begin
         o_scl_ff  <= scl_in;
         o_sda_ff  <= sda_in;
         o_busy_ff <= (op_in != OP_IDLE);
         o_done_ff <= done_in;
         o_rx_ff   <= rx_in;
         o_bin_ff  <= bcd_to_bin(rx_in);
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_scl_level = o_scl_ff;
   assign rsp_sda_level = o_sda_ff;
   assign rsp_busy_res  = o_busy_ff;
   assign rsp_done_res  = o_done_ff;
   assign rsp_rx_byte   = o_rx_ff;
   assign rsp_rx_binary = o_bin_ff;

   // checks on the sequencer
   `IMBE_ASSERT_NOW(a_done_not_busy, clock, reset, rsp_valid_ff && o_done_ff, !o_busy_ff, "done reported while still busy")
   `IMBE_ASSERT_NOW(a_idle_clean, clock, reset, op_ff == OP_IDLE, dly_cnt_ff == '0 && bit_idx_ff == '0, "idle with live counters")
   `IMBE_ASSERT_NOW(a_busy_count, clock, reset, op_ff != OP_IDLE, dly_cnt_ff != '0 && bit_idx_ff <= BITS_PER_BYTE, "busy with empty delay or bit overrun")
   `IMBE_ASSERT_NEXT(a_hold_state, clock, reset, !accept, $stable(op_ff) && $stable(dly_cnt_ff), "state moved without a transaction")

endmodule
